@@ hw/rtl/fvhi_pkg.sv @@
// Shared types and constants for the fenced version hash index.
// No dependencies.
package fvhi_pkg;

    localparam int KEY_W = 64;
    localparam int CNT_W = 11;
    localparam int HOME_W = 10;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_STALE_EPOCH = 2'd1,
        ST_STALE_GEN   = 2'd2,
        ST_FULL_OR_MISS = 2'd3
    } status_t;

    localparam logic MODE_UPSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // one queued command from front to back
    typedef struct packed {
        logic            mode;
        logic [63:0]     id_high;
        logic [63:0]     id_low;
        logic [HOME_W-1:0] home_slot;
        logic [63:0]     epoch;
        logic [63:0]     generation;
        logic            tombstone;
        logic [63:0]     location;
        logic [63:0]     attributes;
    } cmd_t;

    // stored slot contents (key plus entry)
    typedef struct packed {
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [63:0] epoch;
        logic [63:0] generation;
        logic        dead;
        logic [63:0] location;
        logic [63:0] attributes;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef struct packed {
        logic [1:0]       status;
        logic             found;
        logic [63:0]      epoch;
        logic [63:0]      generation;
        logic             tombstone;
        logic [63:0]      location;
        logic [63:0]      attributes;
        logic [CNT_W-1:0] entry_count;
        logic [CNT_W-1:0] live_count;
        logic [CNT_W-1:0] dead_count;
    } result_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_CHECK,
        BK_EMIT,
        BK_CLEAR
    } bk_state_t;

endpackage

@@ hw/rtl/fvhi_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module fvhi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/fvhi_front.sv @@
// Front end: accepts items into a short command queue.
// Depends on fvhi_pkg.
module fvhi_front
    import fvhi_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  cmd_t cmd_in,
    output logic cmd_valid,
    input  logic cmd_take,
    output cmd_t cmd_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t            q_reg [DEPTH];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [AW:0]     cnt_reg;
    logic            do_push, do_pop;

    assign full      = (cnt_reg == (AW+1)'(DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd_out   = q_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    // payload storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_reg] <= cmd_in;
        end
    end

    // pointers and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

endmodule

@@ hw/rtl/fvhi_back.sv @@
// Back end: probe sequencer over slot RAMs, counters and result register.
// Depends on fvhi_pkg and fvhi_ram.
module fvhi_back
    import fvhi_pkg::*;
#(
    parameter int SLOTS = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_data,
    input  logic             cmd_valid,
    output logic             cmd_take,
    input  cmd_t             cmd,
    output logic             res_valid,
    input  logic             res_take,
    output result_t          res
);

    localparam int AW = $clog2(SLOTS);
    localparam int PW = AW + 1;

    bk_state_t        state_reg, state_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [PW-1:0]    probes_reg, probes_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [CNT_W-1:0] limit_reg;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] live_reg, live_next;
    logic [CNT_W-1:0] dead_reg, dead_next;
    logic             rv_reg, rv_next;
    result_t          res_reg, res_next;

    logic             slot_we, used_we, used_wd, used_rd;
    logic [AW-1:0]    slot_wa, used_wa;
    slot_t            slot_wd, slot_rd;
    logic [15:0]      home_ext;

    fvhi_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_slots (
        .clk(clk), .we(slot_we), .waddr(slot_wa), .wdata(slot_wd),
        .raddr(addr_next), .rdata(slot_rd));

    fvhi_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_used (
        .clk(clk), .we(used_we), .waddr(used_wa), .wdata(used_wd),
        .raddr(addr_next), .rdata(used_rd));

    assign res_valid = rv_reg;
    assign res       = res_reg;
    assign home_ext  = 16'(cmd.home_slot);

    always_comb
    begin
        slot_wd.key_high   = cmd.id_high;
        slot_wd.key_low    = cmd.id_low;
        slot_wd.epoch      = cmd.epoch;
        slot_wd.generation = cmd.generation;
        slot_wd.dead       = cmd.tombstone;
        slot_wd.location   = cmd.location;
        slot_wd.attributes = cmd.attributes;
    end

    // probe sequencer: each slot is addressed, then checked (BK_READ, then BK_CHECK, for later probes)
    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        probes_next = probes_reg;
        clr_next    = clr_reg;
        used_next   = used_reg;
        live_next   = live_reg;
        dead_next   = dead_reg;
        rv_next     = rv_reg;
        res_next    = res_reg;
        cmd_take    = 1'b0;
        slot_we     = 1'b0;
        slot_wa     = addr_reg;
        used_we     = 1'b0;
        used_wa     = addr_reg;
        used_wd     = 1'b1;
        if (res_take && rv_reg)
        begin
            rv_next = 1'b0;
        end
        unique case (state_reg)
            BK_CLEAR:
            begin
                used_we  = 1'b1;
                used_wa  = clr_reg;
                used_wd  = 1'b0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(SLOTS-1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                // start only once the result register is free, so a waiting
                // result is never overwritten
                if (cmd_valid && (!rv_reg || res_take))
                begin
                    addr_next   = home_ext[AW-1:0];
                    probes_next = '0;
                    state_next  = BK_CHECK;
                end
            end
            BK_READ:
            begin
                state_next = BK_CHECK;
            end
            BK_CHECK:
            begin
                res_next             = '0;
                res_next.status      = ST_OK;
                if (!used_rd)
                begin
                    // empty slot: miss, insert, or full when the fill limit is reached
                    if (cmd.mode == MODE_LOOKUP)
                    begin
                        res_next.status = ST_FULL_OR_MISS;
                    end
                    else if (used_reg >= limit_reg)
                    begin
                        res_next.status = ST_FULL_OR_MISS;
                    end
                    else
                    begin
                        slot_we   = 1'b1;
                        used_we   = 1'b1;
                        used_next = used_reg + 1'b1;
                        if (cmd.tombstone)
                        begin
                            dead_next = dead_reg + 1'b1;
                        end
                        else
                        begin
                            live_next = live_reg + 1'b1;
                        end
                    end
                    state_next = BK_EMIT;
                end
                else if (slot_rd.key_high == cmd.id_high && slot_rd.key_low == cmd.id_low)
                begin
                    if (cmd.mode == MODE_LOOKUP)
                    begin
                        res_next.found      = 1'b1;
                        res_next.epoch      = slot_rd.epoch;
                        res_next.generation = slot_rd.generation;
                        res_next.tombstone  = slot_rd.dead;
                        res_next.location   = slot_rd.location;
                        res_next.attributes = slot_rd.attributes;
                    end
                    else if (cmd.epoch < slot_rd.epoch)
                    begin
                        res_next.status = ST_STALE_EPOCH;
                    end
                    else if (cmd.epoch == slot_rd.epoch &&
                             cmd.generation < slot_rd.generation)
                    begin
                        res_next.status = ST_STALE_GEN;
                    end
                    else
                    begin
                        slot_we = 1'b1;
                        if (!slot_rd.dead && cmd.tombstone)
                        begin
                            live_next = live_reg - 1'b1;
                            dead_next = dead_reg + 1'b1;
                        end
                        else if (slot_rd.dead && !cmd.tombstone)
                        begin
                            live_next = live_reg + 1'b1;
                            dead_next = dead_reg - 1'b1;
                        end
                    end
                    state_next = BK_EMIT;
                end
                else if (probes_reg == PW'(SLOTS-1))
                begin
                    // whole table probed
                    res_next.status = ST_FULL_OR_MISS;
                    state_next      = BK_EMIT;
                end
                else
                begin
                    addr_next   = addr_reg + 1'b1;
                    probes_next = probes_reg + 1'b1;
                    state_next  = BK_READ;
                end
            end
            BK_EMIT:
            begin
                if (!rv_reg || res_take)
                begin
                    res_next.entry_count = used_reg;
                    res_next.live_count  = live_reg;
                    res_next.dead_count  = dead_reg;
                    rv_next    = 1'b1;
                    cmd_take   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_CLEAR;
            addr_reg   <= '0;
            probes_reg <= '0;
            clr_reg    <= '0;
            limit_reg  <= CNT_W'(716);
            used_reg   <= '0;
            live_reg   <= '0;
            dead_reg   <= '0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            probes_reg <= probes_next;
            clr_reg    <= clr_next;
            used_reg   <= used_next;
            live_reg   <= live_next;
            dead_reg   <= dead_next;
            rv_reg     <= rv_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

endmodule

@@ hw/rtl/fenced_version_hash_index.sv @@
// Fenced version hash index, top level: command queue and probe back end.
// Each item is checked at its home slot in BK_CHECK, then through BK_READ and
// BK_CHECK for each further probe, and leaves via BK_EMIT into the result register.
// The back end handles one item at a time over the single slot RAM read port.
// Reset: counters clear, limit_reg goes to 716, then a clearing pass over all
// SLOTS used bits runs before the first item is processed.
module fenced_version_hash_index
    import fvhi_pkg::*;
#(
    parameter int SLOTS = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              mode,
    input  logic [63:0]       id_high,
    input  logic [63:0]       id_low,
    input  logic [HOME_W-1:0] home_slot,
    input  logic [63:0]       epoch_in,
    input  logic [63:0]       generation_in,
    input  logic              tombstone_in,
    input  logic [63:0]       location_in,
    input  logic [63:0]       attributes_in,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_data,
    output logic              empty,
    input  logic              pop,
    output logic [1:0]        status,
    output logic              found,
    output logic [63:0]       epoch_out,
    output logic [63:0]       generation_out,
    output logic              tombstone_out,
    output logic [63:0]       location_out,
    output logic [63:0]       attributes_out,
    output logic [CNT_W-1:0]  entry_count,
    output logic [CNT_W-1:0]  live_count,
    output logic [CNT_W-1:0]  dead_count
);

    cmd_t    cmd_in, cmd_q;
    logic    cmd_valid, cmd_take, res_valid;
    result_t res;

    always_comb
    begin
        cmd_in.mode       = mode;
        cmd_in.id_high    = id_high;
        cmd_in.id_low     = id_low;
        cmd_in.home_slot  = home_slot;
        cmd_in.epoch      = epoch_in;
        cmd_in.generation = generation_in;
        cmd_in.tombstone  = tombstone_in;
        cmd_in.location   = location_in;
        cmd_in.attributes = attributes_in;
    end

    fvhi_front #(.DEPTH(2)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd_in(cmd_in),
        .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd_out(cmd_q));

    fvhi_back #(.SLOTS(SLOTS)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd_q),
        .res_valid(res_valid), .res_take(pop), .res(res));

    assign empty          = !res_valid;
    assign status         = res.status;
    assign found          = res.found;
    assign epoch_out      = res.epoch;
    assign generation_out = res.generation;
    assign tombstone_out  = res.tombstone;
    assign location_out   = res.location;
    assign attributes_out = res.attributes;
    assign entry_count    = res.entry_count;
    assign live_count     = res.live_count;
    assign dead_count     = res.dead_count;

endmodule

@@ hw/rtl/fvhi_checker.sv @@
// Port-level checks for the fenced version hash index, bound to the top.
// Depends on fvhi_pkg.
module fvhi_checker
    import fvhi_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             empty,
    input logic             pop,
    input logic [1:0]       status,
    input logic             found,
    input logic [CNT_W-1:0] entry_count,
    input logic [CNT_W-1:0] live_count,
    input logic [CNT_W-1:0] dead_count
);

    // a found flag only with ok status
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && found) |-> (status == ST_OK))
        else $error("found with bad status");

    // live and dead split the occupied count
    a_sum: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((live_count + dead_count) == entry_count))
        else $error("counter mismatch");

    // a waiting result holds while not popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(entry_count) && $stable(status)))
        else $error("result changed while waiting");

endmodule

bind fenced_version_hash_index fvhi_checker u_fvhi_checker (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .status(status),
    .found(found), .entry_count(entry_count), .live_count(live_count),
    .dead_count(dead_count));
